// ===== hdl/tcw_pkg.sv =====
// Shared types, constants and the controller state encoding for the text console writer.
// Used by tcw_ctrl, tcw_datapath and text_console_writer_unit; depends on nothing.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLS_DEF   = 80;
  localparam int ROWS_DEF   = 25;
  localparam int DEC_DIGITS = 10;

  localparam logic [7:0] ATTR_RESET   = 8'h0F;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] MINUS_CODE   = 8'h2D;
  localparam logic [7:0] ZERO_CODE    = 8'h30;

  // Reciprocal of ten: (n * RECIP_10) >> RECIP_SHIFT equals n / 10 for every 32-bit n.
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    REQ_PUT_CHAR  = 2'd0,
    REQ_PUT_DEC   = 2'd1,
    REQ_READ_CELL = 2'd2,
    REQ_CLEAR     = 2'd3
  } tcw_req_t;

  typedef struct packed {
    tcw_req_t           req_type;
    logic [7:0]         char_code;
    logic signed [31:0] number;
    logic [10:0]        cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } tcw_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_PLACE,
    ST_WIPE,
    ST_READ,
    ST_RESP
  } tcw_state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PLACE,
    RET_RESP
  } tcw_ret_t;

  typedef struct packed {
    logic capture;
    logic div_mul;
    logic div_rem;
    logic place;
    logic wipe;
    logic read;
    logic respond;
  } tcw_cmd_t;

  typedef struct packed {
    logic need_wipe;
    logic last_char;
    logic wipe_last;
    logic conv_done;
  } tcw_status_t;

endpackage

// ===== hdl/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives the datapath through tcw_cmd_t and reads tcw_status_t.
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  tcw_pkg::tcw_req_t     req,
  input  tcw_pkg::tcw_status_t  status,
  output tcw_pkg::tcw_cmd_t     cmd,
  output logic                  busy
);

  tcw_pkg::tcw_state_t state_r, state_nxt;
  tcw_pkg::tcw_ret_t   ret_r, ret_nxt;

  // After reset the screen store is swept before the first beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::ST_WIPE;
      ret_r   <= tcw_pkg::RET_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          unique case (req)
            tcw_pkg::REQ_PUT_CHAR:  state_nxt = tcw_pkg::ST_PLACE;
            tcw_pkg::REQ_PUT_DEC:   state_nxt = tcw_pkg::ST_MUL;
            tcw_pkg::REQ_READ_CELL: state_nxt = tcw_pkg::ST_READ;
            tcw_pkg::REQ_CLEAR: begin
              state_nxt = tcw_pkg::ST_WIPE;
              ret_nxt   = tcw_pkg::RET_RESP;
            end
            default: state_nxt = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_MUL: state_nxt = tcw_pkg::ST_REM;
      tcw_pkg::ST_REM: begin
        state_nxt = status.conv_done ? tcw_pkg::ST_PLACE : tcw_pkg::ST_MUL;
      end
      tcw_pkg::ST_PLACE: begin
        if (status.need_wipe) begin
          state_nxt = tcw_pkg::ST_WIPE;
          ret_nxt   = tcw_pkg::RET_PLACE;
        end else if (status.last_char) begin
          state_nxt = tcw_pkg::ST_RESP;
        end
      end
      tcw_pkg::ST_WIPE: begin
        if (status.wipe_last) begin
          unique case (ret_r)
            tcw_pkg::RET_PLACE: state_nxt = tcw_pkg::ST_PLACE;
            tcw_pkg::RET_RESP:  state_nxt = tcw_pkg::ST_RESP;
            default:            state_nxt = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_READ: state_nxt = tcw_pkg::ST_RESP;
      tcw_pkg::ST_RESP: state_nxt = tcw_pkg::ST_IDLE;
      default:          state_nxt = tcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      tcw_pkg::ST_MUL:   cmd.div_mul = 1'b1;
      tcw_pkg::ST_REM:   cmd.div_rem = 1'b1;
      tcw_pkg::ST_PLACE: cmd.place   = !status.need_wipe;
      tcw_pkg::ST_WIPE:  cmd.wipe    = 1'b1;
      tcw_pkg::ST_READ:  cmd.read    = 1'b1;
      tcw_pkg::ST_RESP:  cmd.respond = 1'b1;
      default:           busy        = 1'b1;
    endcase
  end

endmodule

// ===== hdl/tcw_datapath.sv =====
// Datapath of the text console writer: screen store, cursor, attribute register,
// decimal digit converter and digit stack, and the result register. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_datapath #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  tcw_pkg::tcw_in_t      in_data,
  input  tcw_pkg::tcw_cmd_t     cmd,
  output tcw_pkg::tcw_status_t  status,
  output logic                  out_valid,
  output tcw_pkg::tcw_out_t     out_data
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CW    = $clog2(COLS + 1);
  localparam int ND    = tcw_pkg::DEC_DIGITS;
  localparam int NW    = $clog2(ND + 1);
  localparam int QW    = 64 - tcw_pkg::RECIP_SHIFT;

  localparam logic [AW-1:0] COLS_A     = AW'(COLS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [CW-1:0] COLS_C     = CW'(COLS);
  localparam logic [RW-1:0] ROWS_R     = RW'(ROWS);
  localparam logic [31:0]   CELLS_32   = 32'(CELLS);

  logic [15:0]    screen_r [CELLS];
  logic [15:0]    rd_q_r;

  logic [7:0]     attr_r, attr_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic           dec_mode_r, dec_mode_nxt;
  logic           sign_pend_r, sign_pend_nxt;
  logic           rd_ok_r, rd_ok_nxt;
  logic [7:0]     char_r, char_nxt;
  logic [AW-1:0]  rd_idx_r, rd_idx_nxt;
  logic [31:0]    mag_r, mag_nxt;
  logic [63:0]    prod_r, prod_nxt;
  logic [3:0]     stk_r [ND];
  logic [3:0]     stk_nxt [ND];
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  wipe_cnt_r, wipe_cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  tcw_pkg::tcw_out_t out_data_r, out_data_nxt;

  logic           wrap;
  logic [RW-1:0]  srow;
  logic [CW-1:0]  scol;
  logic [QW-1:0]  quot;
  logic [31:0]    qx10;
  logic [31:0]    rem_full;
  logic [31:0]    num_u;
  logic [7:0]     cur_char;
  logic           is_nl;
  logic [AW-1:0]  place_addr;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [15:0]    mem_wdata;

  // Cursor as it stands once a pending wrap at the right edge is applied.
  assign wrap = (col_r >= COLS_C);
  assign srow = wrap ? row_r + RW'(1) : row_r;
  assign scol = wrap ? '0 : col_r;

  assign quot     = prod_r[63:tcw_pkg::RECIP_SHIFT];
  assign qx10     = (32'(quot) << 3) + (32'(quot) << 1);
  assign rem_full = mag_r - qx10;
  assign num_u    = in_data.number;

  always_comb begin
    if (!dec_mode_r) begin
      cur_char = char_r;
    end else if (sign_pend_r) begin
      cur_char = tcw_pkg::MINUS_CODE;
    end else begin
      cur_char = tcw_pkg::ZERO_CODE | {4'b0, stk_r[0]};
    end
  end

  assign is_nl      = (cur_char == tcw_pkg::NEWLINE_CODE);
  assign place_addr = AW'(srow) * COLS_A + AW'(scol);

  assign status.need_wipe = (srow >= ROWS_R);
  assign status.last_char = !dec_mode_r || (!sign_pend_r && cnt_r == NW'(1));
  assign status.wipe_last = (wipe_cnt_r == LAST_CELL);
  assign status.conv_done = (quot == '0);

  assign mem_we    = cmd.wipe || (cmd.place && !is_nl);
  assign mem_waddr = cmd.wipe ? wipe_cnt_r : place_addr;
  assign mem_wdata = {attr_r, cmd.wipe ? tcw_pkg::SPACE_CODE : cur_char};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_r[mem_waddr] <= mem_wdata;
    end
    if (cmd.read && rd_ok_r) begin
      rd_q_r <= screen_r[rd_idx_r];
    end
  end

  always_comb begin
    attr_nxt      = cfg_we ? cfg_wdata : attr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    dec_mode_nxt  = dec_mode_r;
    sign_pend_nxt = sign_pend_r;
    rd_ok_nxt     = rd_ok_r;
    char_nxt      = char_r;
    rd_idx_nxt    = rd_idx_r;
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    cnt_nxt       = cnt_r;
    wipe_cnt_nxt  = wipe_cnt_r;
    out_valid_nxt = cmd.respond;
    out_data_nxt  = out_data_r;
    for (int i = 0; i < ND; i++) begin
      stk_nxt[i] = stk_r[i];
    end

    if (cmd.capture) begin
      dec_mode_nxt  = (in_data.req_type == tcw_pkg::REQ_PUT_DEC);
      sign_pend_nxt = (in_data.req_type == tcw_pkg::REQ_PUT_DEC) && num_u[31];
      rd_ok_nxt     = (in_data.req_type == tcw_pkg::REQ_READ_CELL) &&
                      ({21'b0, in_data.cell_index} < CELLS_32);
      char_nxt      = in_data.char_code;
      rd_idx_nxt    = AW'(in_data.cell_index);
      // The most negative value negates to itself, which is its unsigned magnitude.
      mag_nxt       = num_u[31] ? (~num_u + 32'd1) : num_u;
      cnt_nxt       = '0;
    end

    if (cmd.div_mul) begin
      prod_nxt = 64'(mag_r) * 64'(tcw_pkg::RECIP_10);
    end

    // Digits come out least significant first and are stacked for printing.
    if (cmd.div_rem) begin
      stk_nxt[0] = rem_full[3:0];
      for (int i = 1; i < ND; i++) begin
        stk_nxt[i] = stk_r[i-1];
      end
      cnt_nxt = cnt_r + NW'(1);
      mag_nxt = 32'(quot);
    end

    if (cmd.place) begin
      if (is_nl) begin
        row_nxt = srow + RW'(1);
        col_nxt = '0;
      end else begin
        row_nxt = srow;
        col_nxt = scol + CW'(1);
      end
      if (dec_mode_r) begin
        if (sign_pend_r) begin
          sign_pend_nxt = 1'b0;
        end else begin
          for (int i = 0; i < ND - 1; i++) begin
            stk_nxt[i] = stk_r[i+1];
          end
          cnt_nxt = cnt_r - NW'(1);
        end
      end
    end

    if (cmd.wipe) begin
      row_nxt      = '0;
      col_nxt      = '0;
      wipe_cnt_nxt = status.wipe_last ? '0 : wipe_cnt_r + AW'(1);
    end

    if (cmd.respond) begin
      out_data_nxt.read_data  = rd_ok_r ? rd_q_r : 16'h0000;
      out_data_nxt.cursor_row = 5'(row_r);
      out_data_nxt.cursor_col = 7'(col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= tcw_pkg::ATTR_RESET;
      row_r       <= '0;
      col_r       <= '0;
      dec_mode_r  <= 1'b0;
      sign_pend_r <= 1'b0;
      rd_ok_r     <= 1'b0;
      cnt_r       <= '0;
      wipe_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      attr_r      <= attr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      dec_mode_r  <= dec_mode_nxt;
      sign_pend_r <= sign_pend_nxt;
      rd_ok_r     <= rd_ok_nxt;
      cnt_r       <= cnt_nxt;
      wipe_cnt_r  <= wipe_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    rd_idx_r   <= rd_idx_nxt;
    mag_r      <= mag_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    for (int i = 0; i < ND; i++) begin
      stk_r[i] <= stk_nxt[i];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/text_console_writer_unit.sv =====
// Put character: the character is placed, after the store is cleared if the cursor stands
// below the bottom row once a pending wrap is applied; then the result beat follows.
// Read cell reads the store and clear blanks it. Put decimal: the divide-by-ten multiplier
// yields the digits, then the sign and the digits are placed, with the same clear rule.
// One request at a time; busy is high until the result beat. Results cannot be stalled.
// Reset sweeps the ROWS*COLS store (2000 cells by default) to blanks with busy high.
`timescale 1ns / 1ps

module text_console_writer_unit #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tcw_pkg::tcw_in_t  in_data,
  output logic              out_valid,
  output tcw_pkg::tcw_out_t out_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  tcw_pkg::tcw_cmd_t    cmd;
  tcw_pkg::tcw_status_t status;

  tcw_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .req    (in_data.req_type),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tcw_console_checker.sv =====
// Checker for the text console writer: watches the request, result and attribute ports,
// keeps its own copy of the screen and cursor, and compares every result beat.
// Depends on tcw_pkg for the beat types and character codes.
`timescale 1ns / 1ps

module tcw_console_checker #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  tcw_pkg::tcw_in_t  in_data,
  input  logic              out_valid,
  input  tcw_pkg::tcw_out_t out_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output int                fail_count,
  output int                outstanding
);

  localparam int CELLS = ROWS * COLS;

  logic [15:0]       screen [0:CELLS-1];
  int                row_pos;
  int                col_pos;
  logic [7:0]        attr;
  tcw_pkg::tcw_out_t replies [$];
  int                errs = 0;

  assign fail_count = errs;

  initial outstanding = 0;

  task automatic blank_screen();
    for (int k = 0; k < CELLS; k++) begin
      screen[k] = {attr, tcw_pkg::SPACE_CODE};
    end
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic place_glyph(input logic [7:0] code);
    int addr;
    // The cursor is settled before every character: wrap first, then clear at the bottom.
    if (col_pos >= COLS) begin
      row_pos++;
      col_pos = 0;
    end
    if (row_pos >= ROWS) begin
      blank_screen();
    end
    if (code == tcw_pkg::NEWLINE_CODE) begin
      row_pos++;
      col_pos = 0;
    end else begin
      addr = row_pos * COLS + col_pos;
      if (addr < CELLS) begin
        screen[addr] = {attr, code};
      end
      col_pos++;
    end
  endtask

  task automatic print_decimal(input logic signed [31:0] value);
    logic [31:0] mag;
    logic [7:0]  digits [0:9];
    int          n;
    mag = value;
    n = 0;
    if (mag == 32'd0) begin
      place_glyph(tcw_pkg::ZERO_CODE);
      return;
    end
    // The magnitude is taken unsigned, so the most negative value prints in full.
    if (value < 0) begin
      place_glyph(tcw_pkg::MINUS_CODE);
      mag = 32'd0 - mag;
    end
    while (mag != 32'd0) begin
      digits[n] = tcw_pkg::ZERO_CODE + 8'(mag % 32'd10);
      mag = mag / 32'd10;
      n++;
    end
    while (n > 0) begin
      n--;
      place_glyph(digits[n]);
    end
  endtask

  task automatic predict_request(input tcw_pkg::tcw_in_t req);
    tcw_pkg::tcw_out_t res;
    res = '0;
    case (req.req_type)
      tcw_pkg::REQ_PUT_CHAR: place_glyph(req.char_code);
      tcw_pkg::REQ_PUT_DEC: print_decimal(req.number);
      tcw_pkg::REQ_READ_CELL: begin
        if (int'(req.cell_index) < CELLS) begin
          res.read_data = screen[req.cell_index];
        end
      end
      default: blank_screen();
    endcase
    res.cursor_row = 5'(row_pos);
    res.cursor_col = 7'(col_pos);
    replies.push_back(res);
  endtask

  always @(posedge clk) begin
    tcw_pkg::tcw_out_t want;
    if (!rst_n) begin
      attr = tcw_pkg::ATTR_RESET;
      blank_screen();
      replies.delete();
    end else begin
      if (cfg_we) begin
        attr = cfg_wdata;
      end
      if (start && !busy) begin
        predict_request(in_data);
      end
      if (out_valid) begin
        if (replies.size() == 0) begin
          $error("result beat with no request waiting: read_data %h row %0d col %0d",
                 out_data.read_data, out_data.cursor_row, out_data.cursor_col);
          errs++;
        end else begin
          want = replies.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data expected %h actual %h", want.read_data, out_data.read_data);
            errs++;
          end
          if (out_data.cursor_row !== want.cursor_row) begin
            $error("cursor_row expected %0d actual %0d", want.cursor_row, out_data.cursor_row);
            errs++;
          end
          if (out_data.cursor_col !== want.cursor_col) begin
            $error("cursor_col expected %0d actual %0d", want.cursor_col, out_data.cursor_col);
            errs++;
          end
        end
      end
    end
    outstanding <= replies.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the text console writer testbench: clock, reset, request stimulus and the verdict.
// Depends on tcw_pkg, text_console_writer_unit and tcw_console_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT_CYCLES = 12_000_000;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 200;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  tcw_pkg::tcw_in_t  in_data = '0;
  logic              out_valid;
  tcw_pkg::tcw_out_t out_data;
  logic              cfg_we = 1'b0;
  logic [7:0]        cfg_wdata = 8'h00;
  int                fail_count;
  int                outstanding;
  int                cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_console_writer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tcw_console_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic tcw_pkg::tcw_in_t make_req(tcw_pkg::tcw_req_t kind, logic [7:0] ch,
                                                logic [31:0] num, logic [10:0] idx);
    tcw_pkg::tcw_in_t req;
    req.req_type   = kind;
    req.char_code  = ch;
    req.number     = num;
    req.cell_index = idx;
    return req;
  endfunction

  // Profile 0 is newline heavy to reach the bottom edge, 1 runs long lines to force wraps.
  function automatic tcw_pkg::tcw_in_t random_req(int profile);
    tcw_pkg::tcw_in_t req;
    int               roll;
    int               lf_odds;
    int               dec_top;
    req = make_req(tcw_pkg::tcw_req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   $urandom, 11'($urandom_range(0, 2047)));
    lf_odds = (profile == 0) ? 4 : (profile == 1) ? 64 : 12;
    dec_top = (profile == 1) ? 50 : 30;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      req.req_type = tcw_pkg::REQ_CLEAR;
    end else if (roll < 20) begin
      req.req_type = tcw_pkg::REQ_READ_CELL;
      if ($urandom_range(0, 4) != 0) begin
        req.cell_index = 11'($urandom_range(0, 1999));
      end
    end else if (roll < dec_top) begin
      req.req_type = tcw_pkg::REQ_PUT_DEC;
      if ($urandom_range(0, 3) == 0) begin
        req.number = $signed($urandom_range(0, 20)) - 10;
      end
    end else begin
      req.req_type = tcw_pkg::REQ_PUT_CHAR;
      if ($urandom_range(1, lf_odds) == 1) begin
        req.char_code = tcw_pkg::NEWLINE_CODE;
      end
    end
    return req;
  endfunction

  // Start stays high from one beat to the next unless a gap is taken.
  task automatic send_req(input tcw_pkg::tcw_in_t req);
    in_data <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic write_attr(input logic [7:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int roll;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the attribute left at its reset value.
    send_req(make_req(tcw_pkg::REQ_PUT_CHAR, 8'h48, $urandom, 11'($urandom)));
    send_req(make_req(tcw_pkg::REQ_PUT_CHAR, 8'h00, $urandom, 11'($urandom)));
    send_req(make_req(tcw_pkg::REQ_PUT_CHAR, 8'hFF, $urandom, 11'($urandom)));
    send_req(make_req(tcw_pkg::REQ_PUT_CHAR, tcw_pkg::NEWLINE_CODE, $urandom, 11'($urandom)));
    send_req(make_req(tcw_pkg::REQ_PUT_DEC, 8'($urandom), 32'd0, 11'($urandom)));
    send_req(make_req(tcw_pkg::REQ_PUT_DEC, 8'($urandom), 32'hFFFF_FFFF, 11'($urandom)));
    send_req(make_req(tcw_pkg::REQ_PUT_DEC, 8'($urandom), 32'h8000_0000, 11'($urandom)));
    send_req(make_req(tcw_pkg::REQ_PUT_DEC, 8'($urandom), 32'h7FFF_FFFF, 11'($urandom)));
    send_req(make_req(tcw_pkg::REQ_PUT_DEC, 8'($urandom), 32'd12345, 11'($urandom)));
    send_req(make_req(tcw_pkg::REQ_READ_CELL, 8'($urandom), $urandom, 11'd0));
    send_req(make_req(tcw_pkg::REQ_READ_CELL, 8'($urandom), $urandom, 11'd1));
    send_req(make_req(tcw_pkg::REQ_READ_CELL, 8'($urandom), $urandom, 11'd2));
    send_req(make_req(tcw_pkg::REQ_READ_CELL, 8'($urandom), $urandom, 11'd80));
    send_req(make_req(tcw_pkg::REQ_READ_CELL, 8'($urandom), $urandom, 11'd1999));
    send_req(make_req(tcw_pkg::REQ_READ_CELL, 8'($urandom), $urandom, 11'd2000));
    send_req(make_req(tcw_pkg::REQ_READ_CELL, 8'($urandom), $urandom, 11'd2047));
    send_req(make_req(tcw_pkg::REQ_CLEAR, 8'($urandom), $urandom, 11'($urandom)));
    send_req(make_req(tcw_pkg::REQ_READ_CELL, 8'($urandom), $urandom, 11'd0));
    send_req(make_req(tcw_pkg::REQ_PUT_CHAR, 8'h5A, $urandom, 11'($urandom)));
    send_req(make_req(tcw_pkg::REQ_READ_CELL, 8'($urandom), $urandom, 11'd0));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 0) begin
        write_attr(8'h00);
      end else if (p == 1) begin
        write_attr(8'hFF);
      end else begin
        write_attr(8'($urandom_range(0, 255)));
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_req(random_req(p % 3));
        roll = $urandom_range(0, 99);
        if (roll == 0) begin
          drain();
        end else if (roll >= 90) begin
          idle_gap($urandom_range(10, 40));
        end else if (roll >= 60) begin
          idle_gap($urandom_range(1, 3));
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
